[rtl/smx_pkg.sv]
// Package: opcodes, error codes and shared types for the stack machine execute unit
`default_nettype none
package smx_pkg;

    localparam int unsigned StackDepthDef = 256;
    localparam int unsigned IpBitsDef     = 16;

    typedef enum logic [4:0] {
        OP_PUSH    = 5'd0,
        OP_DUP     = 5'd1,
        OP_DROP    = 5'd2,
        OP_SWAP    = 5'd3,
        OP_NOT     = 5'd4,
        OP_LSTART  = 5'd5,
        OP_LEND    = 5'd6,
        OP_OUTCHAR = 5'd7,
        OP_OUTNUM  = 5'd8,
        OP_INCHAR  = 5'd9,
        OP_INNUM   = 5'd10,
        OP_ADD     = 5'd11,
        OP_SUB     = 5'd12,
        OP_MUL     = 5'd13,
        OP_GT      = 5'd14,
        OP_DIV     = 5'd15,
        OP_MOD     = 5'd16
    } t_op;

    localparam logic [2:0] E_OK    = 3'd0;
    localparam logic [2:0] E_UNDER = 3'd1;
    localparam logic [2:0] E_DIV0  = 3'd2;
    localparam logic [2:0] E_CHAR  = 3'd3;
    localparam logic [2:0] E_OVER  = 3'd4;
    localparam logic [2:0] E_HALT  = 3'd5;

    // Decoded instruction as it leaves the front end
    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  pops;      // entries needed on the stack
        logic        grows;     // pushes one new entry
        logic        binop;     // add..mod
        logic        divop;     // div or mod
        logic [63:0] operand;
        logic [63:0] read_value;
    } t_dec;

    localparam int unsigned DecBits = $bits(t_dec);

endpackage
`default_nettype wire

[rtl/smx_front.sv]
// Front end: accepts instruction items, classifies them and queues them for execution
`default_nettype none
module smx_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [4:0]         i_kind,
    input  wire logic [63:0]        i_operand,
    input  wire logic [63:0]        i_read_value,
    output logic                    o_q_valid,
    input  wire logic               i_q_ready,
    output smx_pkg::t_dec           o_q_data
);
    import smx_pkg::*;

    // Two-entry queue between front and back
    t_dec       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_dec       w_dec;
    logic       w_push, w_pop;

    // Classification of the opcode
    always_comb begin
        w_dec            = '0;
        w_dec.kind       = i_kind;
        w_dec.operand    = i_operand;
        w_dec.read_value = i_read_value;
        if (i_kind > 5'd16) begin
            w_dec.pops = 2'd0;
        end else begin
            unique case (t_op'(i_kind))
                OP_PUSH, OP_INCHAR, OP_INNUM: begin
                    w_dec.pops  = 2'd0;
                    w_dec.grows = 1'b1;
                end
                OP_DUP: begin
                    w_dec.pops  = 2'd1;
                    w_dec.grows = 1'b1;
                end
                OP_SWAP: w_dec.pops = 2'd2;
                OP_ADD, OP_SUB, OP_MUL, OP_GT: begin
                    w_dec.pops  = 2'd2;
                    w_dec.binop = 1'b1;
                end
                OP_DIV, OP_MOD: begin
                    w_dec.pops  = 2'd2;
                    w_dec.binop = 1'b1;
                    w_dec.divop = 1'b1;
                end
                default: w_dec.pops = 2'd1;
            endcase
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_dec;
        end
    end

endmodule
`default_nettype wire

[rtl/smx_divider.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module smx_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [63:0]      o_rem
);
    import smx_pkg::*;

    logic        r_busy, r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_q, r_d;
    logic [64:0] r_r;
    logic        r_qneg, r_rneg;
    logic [64:0] w_sh, w_sub;
    logic [63:0] w_ua, w_ub;

    assign w_ua  = i_a[63] ? (64'd0 - i_a) : i_a;
    assign w_ub  = i_b[63] ? (64'd0 - i_b) : i_b;
    assign w_sh  = {r_r[63:0], r_q[63]};
    assign w_sub = w_sh - {1'b0, r_d};

    assign o_done = r_done;
    assign o_quot = r_qneg ? (64'd0 - r_q) : r_q;
    assign o_rem  = r_rneg ? (64'd0 - r_r[63:0]) : r_r[63:0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= w_ua;
            r_d    <= w_ub;
            r_r    <= '0;
            r_qneg <= i_a[63] ^ i_b[63];
            r_rneg <= i_a[63];
        end else if (r_busy) begin
            if (!w_sub[64]) begin
                r_r <= w_sub;
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

[rtl/smx_back.sv]
// Back end: stack memory, pointer, error checks and execution of one instruction
`default_nettype none
module smx_back #(
    parameter int unsigned STACK_DEPTH = smx_pkg::StackDepthDef,
    parameter int unsigned IP_BITS     = smx_pkg::IpBitsDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire smx_pkg::t_dec i_q_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [15:0]        o_next_ip,
    output logic               o_out_valid,
    output logic               o_out_is_number,
    output logic [63:0]        o_out_value,
    output logic [2:0]         o_error_code
);
    import smx_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [63:0] r_mem [STACK_DEPTH];
    logic [63:0] r_top, r_sec;
    t_dec        r_ins;
    logic [CW-1:0]      r_cnt;
    logic [IP_BITS-1:0] r_ip;
    logic        r_halt;

    logic [15:0] r_onip;
    logic        r_oval, r_onum;
    logic [63:0] r_oval_d;
    logic [2:0]  r_oerr;

    // Memory port requests
    logic          w_wr;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_wdata;
    logic          w_wr2;
    logic [AW-1:0] w_waddr2;
    logic [63:0]   w_wdata2;
    logic [AW-1:0] w_ra1, w_ra2;

    logic        w_div_start, w_div_done;
    logic [63:0] w_quot, w_rem;
    logic [63:0] r_mul_ll;
    logic [31:0] r_mul_hl, r_mul_lh;
    logic [63:0] w_prod;

    logic [CW-1:0]      w_cm1, w_cm2;
    logic [IP_BITS-1:0] w_ipinc, w_ipop;
    logic [2:0]         w_err;
    logic               w_bneg1;
    logic               w_char_ok;

    assign w_cm1   = r_cnt - CW'(1);
    assign w_cm2   = r_cnt - CW'(2);
    assign w_ipinc = r_ip + IP_BITS'(1);
    assign w_ipop  = r_ins.operand[IP_BITS-1:0];
    assign w_ra1   = w_cm1[AW-1:0];
    assign w_ra2   = w_cm2[AW-1:0];
    assign w_bneg1 = (r_top == '1);
    assign w_char_ok = (r_top[63:21] == '0) && (r_top[20:0] <= 21'h10FFFF)
                       && !((r_top[20:0] >= 21'h00D800) && (r_top[20:0] <= 21'h00DFFF));
    assign w_prod  = r_mul_ll + {r_mul_hl + r_mul_lh, 32'd0};

    assign o_q_ready = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_next_ip       = r_onip;
    assign o_out_valid     = r_oval;
    assign o_out_is_number = r_onum;
    assign o_out_value     = r_oval_d;
    assign o_error_code    = r_oerr;

    smx_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (r_sec),
        .i_b     (r_top),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Error check for the instruction in the execute stage
    always_comb begin
        w_err = E_OK;
        if (r_halt) begin
            w_err = E_HALT;
        end else if (r_cnt < CW'(r_ins.pops)) begin
            w_err = E_UNDER;
        end else if (r_ins.grows && (r_cnt >= CW'(STACK_DEPTH))) begin
            w_err = E_OVER;
        end else if (r_ins.divop && (r_top == '0)) begin
            w_err = E_DIV0;
        end else if ((r_ins.kind == OP_OUTCHAR) && !w_char_ok) begin
            w_err = E_CHAR;
        end
    end

    assign w_div_start = (r_state == S_EXEC) && (w_err == E_OK)
                         && r_ins.divop && !w_bneg1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = w_div_start ? S_DIV : S_OUT;
            S_DIV:  if (w_div_done) n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Stack writes
    always_comb begin
        w_wr     = 1'b0;
        w_waddr  = w_ra2;
        w_wdata  = r_top;
        w_wr2    = 1'b0;
        w_waddr2 = w_ra1;
        w_wdata2 = r_sec;
        if ((r_state == S_EXEC) && (w_err == E_OK)) begin
            if (r_ins.kind <= 5'd16) begin
                unique case (t_op'(r_ins.kind))
                    OP_PUSH: begin
                        w_wr = 1'b1; w_waddr = r_cnt[AW-1:0]; w_wdata = r_ins.operand;
                    end
                    OP_INCHAR, OP_INNUM: begin
                        w_wr = 1'b1; w_waddr = r_cnt[AW-1:0]; w_wdata = r_ins.read_value;
                    end
                    OP_DUP: begin
                        w_wr = 1'b1; w_waddr = r_cnt[AW-1:0]; w_wdata = r_top;
                    end
                    OP_SWAP: begin
                        w_wr = 1'b1; w_waddr = w_ra2; w_wdata = r_top;
                        w_wr2 = 1'b1;
                    end
                    OP_NOT: begin
                        w_wr = 1'b1; w_waddr = w_ra1; w_wdata = {63'd0, r_top == '0};
                    end
                    OP_ADD: begin
                        w_wr = 1'b1; w_wdata = r_sec + r_top;
                    end
                    OP_SUB: begin
                        w_wr = 1'b1; w_wdata = r_sec - r_top;
                    end
                    OP_MUL: begin
                        w_wr = 1'b1; w_wdata = w_prod;
                    end
                    OP_GT: begin
                        w_wr = 1'b1; w_wdata = {63'd0, $signed(r_sec) > $signed(r_top)};
                    end
                    OP_DIV: begin
                        w_wr = w_bneg1; w_wdata = 64'd0 - r_sec;
                    end
                    OP_MOD: begin
                        w_wr = w_bneg1; w_wdata = 64'd0;
                    end
                    default: ;
                endcase
            end
        end else if ((r_state == S_DIV) && w_div_done) begin
            // count already dropped by one, so the old second entry is now the top
            w_wr    = 1'b1;
            w_waddr = w_ra1;
            w_wdata = (r_ins.kind == OP_DIV) ? w_quot : w_rem;
        end
    end

    // Stack memory: two write ports, the second used only by swap, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_waddr] <= w_wdata;
        if (w_wr2) r_mem[w_waddr2] <= w_wdata2;
        r_top <= r_mem[w_ra1];
        r_sec <= r_mem[w_ra2];
    end

    // Low 64-bit product from three 32x32 partial products, registered before use
    always_ff @(posedge i_clk) begin
        r_mul_ll <= 64'(r_sec[31:0]) * 64'(r_top[31:0]);
        r_mul_hl <= 32'(r_sec[63:32] * r_top[31:0]);
        r_mul_lh <= 32'(r_sec[31:0] * r_top[63:32]);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_ready && i_q_valid) r_ins <= i_q_data;
    end

    // Architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ip    <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_oval   <= 1'b0;
                r_onum   <= 1'b0;
                r_oval_d <= '0;
                r_oerr   <= w_err;
                if (w_err != E_OK) begin
                    r_halt <= 1'b1;
                    r_onip <= 16'(r_ip);
                end else begin
                    r_ip   <= w_ipinc;
                    r_onip <= 16'(w_ipinc);
                    if (r_ins.grows) r_cnt <= r_cnt + CW'(1);
                    else if (r_ins.binop || r_ins.kind == OP_DROP) r_cnt <= w_cm1;
                    if (((r_ins.kind == OP_LSTART) && (r_top == '0))
                        || ((r_ins.kind == OP_LEND) && (r_top != '0))) begin
                        r_ip   <= w_ipop;
                        r_onip <= 16'(w_ipop);
                    end
                    if ((r_ins.kind == OP_OUTCHAR) || (r_ins.kind == OP_OUTNUM)) begin
                        r_cnt    <= w_cm1;
                        r_oval   <= 1'b1;
                        r_onum   <= (r_ins.kind == OP_OUTNUM);
                        r_oval_d <= r_top;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/stack_machine_execute_unit_top.sv]
// Top level of the stack machine execute unit
`default_nettype none
// Executes one 64-bit stack-machine instruction per input transfer and returns one
// result per instruction (next pointer, optional output value, error code). A front
// queue of two entries takes new instructions while the back end works. Most
// instructions pass through queue pop, stack read, execute and result hold in the back
// end; div and mod also wait in a divide state for the bit-serial divider.
// The stack memory has no clearing pass; its contents are undefined until pushed.
module stack_machine_execute_unit_top #(
    parameter int unsigned STACK_DEPTH = smx_pkg::StackDepthDef,
    parameter int unsigned IP_BITS     = smx_pkg::IpBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [4:0]  i_kind,
    input  wire logic [63:0] i_operand,
    input  wire logic [63:0] i_read_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_next_ip,
    output logic             o_out_valid,
    output logic             o_out_is_number,
    output logic [63:0]      o_out_value,
    output logic [2:0]       o_error_code
);
    import smx_pkg::*;

    logic w_q_valid, w_q_ready;
    t_dec w_q_data;

    smx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_operand    (i_operand),
        .i_read_value (i_read_value),
        .o_q_valid    (w_q_valid),
        .i_q_ready    (w_q_ready),
        .o_q_data     (w_q_data)
    );

    smx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .IP_BITS     (IP_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .o_q_ready       (w_q_ready),
        .i_q_data        (w_q_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_next_ip       (o_next_ip),
        .o_out_valid     (o_out_valid),
        .o_out_is_number (o_out_is_number),
        .o_out_value     (o_out_value),
        .o_error_code    (o_error_code)
    );

endmodule
`default_nettype wire

[tb/smx_checker.sv]
// Checker: predicts each instruction result and compares it with the block output
`default_nettype none
module smx_checker (
    input  wire logic        clk,
    input  wire logic        in_xfer,
    input  wire logic [4:0]  in_kind,
    input  wire logic [63:0] in_operand,
    input  wire logic [63:0] in_read_value,
    input  wire logic        res_xfer,
    input  wire logic [15:0] res_next_ip,
    input  wire logic        res_out_valid,
    input  wire logic        res_out_is_number,
    input  wire logic [63:0] res_out_value,
    input  wire logic [2:0]  res_error_code,
    output int               pending,
    output int               errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import smx_pkg::*;

    localparam int Depth = StackDepthDef;

    typedef struct packed {
        logic [15:0] next_ip;
        logic        out_valid;
        logic        out_is_number;
        logic [63:0] out_value;
        logic [2:0]  error_code;
    } t_step_result;

    // machine state as the checker sees it
    logic [63:0] data_stack [Depth];
    int          depth_now;
    logic [15:0] ip_now;
    bit          is_halted;

    t_step_result result_fifo[$];

    initial begin
        depth_now = 0;
        ip_now    = '0;
        is_halted = 0;
        errors    = 0;
    end

    assign pending = result_fifo.size();

    function automatic int operands_needed(logic [4:0] k);
        case (k)
            OP_PUSH, OP_INCHAR, OP_INNUM: return 0;
            OP_DUP, OP_DROP, OP_NOT, OP_LSTART, OP_LEND, OP_OUTCHAR, OP_OUTNUM: return 1;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_DIV, OP_MOD: return 2;
            default: return 0;
        endcase
    endfunction

    function automatic bit is_code_point(logic [63:0] v);
        return !v[63] && v <= 64'h10FFFF && !(v >= 64'hD800 && v <= 64'hDFFF);
    endfunction

    // execute one instruction on the shadow machine
    task automatic execute_instruction(logic [4:0] k, logic [63:0] opnd, logic [63:0] rv);
        t_step_result     r;
        logic [15:0]      nip;
        logic [63:0]      a, b, t, res;
        logic signed [63:0] sa, sb;
        bit               grows;
        nip   = ip_now + 16'd1;
        r     = '0;
        r.error_code = E_OK;
        grows = (k == OP_PUSH || k == OP_DUP || k == OP_INCHAR || k == OP_INNUM);
        if (is_halted) begin
            r.error_code = E_HALT;
        end else if (depth_now < operands_needed(k)) begin
            r.error_code = E_UNDER;
        end else if (grows && depth_now >= Depth) begin
            r.error_code = E_OVER;
        end else if (k >= OP_ADD && k <= OP_MOD) begin
            b   = data_stack[depth_now-1];
            a   = data_stack[depth_now-2];
            sa  = a;
            sb  = b;
            res = '0;
            case (k)
                OP_ADD: res = a + b;
                OP_SUB: res = a - b;
                OP_MUL: res = a * b;
                OP_GT:  res = (sa > sb) ? 64'd1 : 64'd0;
                default: begin
                    if (b == 0) r.error_code = E_DIV0;
                    else if (sb == -64'sd1) res = (k == OP_DIV) ? (64'd0 - a) : 64'd0;
                    else res = (k == OP_DIV) ? sa / sb : sa % sb;
                end
            endcase
            if (r.error_code == E_OK) begin
                data_stack[depth_now-2] = res;
                depth_now--;
            end
        end else begin
            case (k)
                OP_PUSH: begin
                    data_stack[depth_now] = opnd;
                    depth_now++;
                end
                OP_DUP: begin
                    data_stack[depth_now] = data_stack[depth_now-1];
                    depth_now++;
                end
                OP_DROP: depth_now--;
                OP_SWAP: begin
                    t = data_stack[depth_now-1];
                    data_stack[depth_now-1] = data_stack[depth_now-2];
                    data_stack[depth_now-2] = t;
                end
                OP_NOT: data_stack[depth_now-1] = (data_stack[depth_now-1] == 0) ? 64'd1 : 64'd0;
                OP_LSTART: if (data_stack[depth_now-1] == 0) nip = opnd[15:0];
                OP_LEND:   if (data_stack[depth_now-1] != 0) nip = opnd[15:0];
                OP_OUTCHAR: begin
                    t = data_stack[depth_now-1];
                    if (!is_code_point(t)) begin
                        r.error_code = E_CHAR;
                    end else begin
                        depth_now--;
                        r.out_valid = 1;
                        r.out_value = t;
                    end
                end
                OP_OUTNUM: begin
                    depth_now--;
                    r.out_valid     = 1;
                    r.out_is_number = 1;
                    r.out_value     = data_stack[depth_now];
                end
                OP_INCHAR, OP_INNUM: begin
                    data_stack[depth_now] = rv;
                    depth_now++;
                end
                default: ;
            endcase
        end
        if (r.error_code != E_OK) begin
            is_halted = 1;
            nip = ip_now;
        end
        ip_now    = nip;
        r.next_ip = nip;
        result_fifo = {result_fifo, r};
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // watch both channels
    always @(posedge clk) begin
        t_step_result e;
        if (in_xfer) execute_instruction(in_kind, in_operand, in_read_value);
        if (res_xfer) begin
            if (result_fifo.size() == 0) begin
                report("result with nothing outstanding", res_next_ip, 0);
            end else begin
                e = result_fifo.pop_front();
                if (res_next_ip != e.next_ip) report("next_ip", res_next_ip, e.next_ip);
                if (res_out_valid != e.out_valid)
                    report("out_valid", res_out_valid, e.out_valid);
                if (res_out_is_number != e.out_is_number)
                    report("out_is_number", res_out_is_number, e.out_is_number);
                if (res_out_value != e.out_value)
                    report("out_value", res_out_value, e.out_value);
                if (res_error_code != e.error_code)
                    report("error_code", res_error_code, e.error_code);
            end
        end
    end
endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import smx_pkg::*;

    localparam int CycleLimit = 2000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [4:0]  i_kind = '0;
    logic [63:0] i_operand = '0;
    logic [63:0] i_read_value = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [15:0] o_next_ip;
    logic        o_out_valid;
    logic        o_out_is_number;
    logic [63:0] o_out_value;
    logic [2:0]  o_error_code;

    int  pending, errors;
    int  cycles = 0;
    int  stack_depth = 0;   // entries the stimulus believes are on the stack
    bit  no_gaps = 0;       // stretch with no idling on either side
    bit  hold_request = 0;  // ask the receiver for a long hold-off

    always #2 i_clk = ~i_clk;

    stack_machine_execute_unit_top u_dut (.*);

    smx_checker u_checker (
        .clk              (i_clk),
        .in_xfer          (i_valid && o_ready),
        .in_kind          (i_kind),
        .in_operand       (i_operand),
        .in_read_value    (i_read_value),
        .res_xfer         (o_valid && i_ready),
        .res_next_ip      (o_next_ip),
        .res_out_valid    (o_out_valid),
        .res_out_is_number(o_out_is_number),
        .res_out_value    (o_out_value),
        .res_error_code   (o_error_code),
        .pending          (pending),
        .errors           (errors)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("stack_machine_execute_unit_top: mismatch");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (hold_request) begin
                hold_request = 0;
                stall = 300;
            end
            if (stall > 0) begin
                i_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            2: return '1;
            3: return '0;
            4: return 64'($urandom_range(0, 20));
            5: return -64'($urandom_range(1, 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_code_point();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return 64'hD7FF;
            2: return 64'hE000;
            3: return 64'h10FFFF;
            4: return 64'($urandom_range(16'hE000, 32'h10FFFF));
            default: return 64'($urandom_range(0, 16'hD7FF));
        endcase
    endfunction

    // one instruction transfer; tracks expected stack depth for error-free ops
    task automatic issue(logic [4:0] k, logic [63:0] opnd = '0, logic [63:0] rv = '0);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1;
        i_kind       <= k;
        i_operand    <= opnd;
        i_read_value <= rv;
        do @(posedge i_clk); while (!o_ready);
        case (k)
            OP_PUSH, OP_DUP, OP_INCHAR, OP_INNUM: stack_depth++;
            OP_DROP, OP_OUTCHAR, OP_OUTNUM, OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_DIV, OP_MOD:
                stack_depth--;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // one random instruction that cannot fault
    task automatic random_instruction();
        logic [4:0] k;
        logic [63:0] b;
        int need;
        k = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
        case (k)
            OP_PUSH, OP_INCHAR, OP_INNUM: need = 0;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_GT: need = 2;
            OP_DIV, OP_MOD: need = 1;
            OP_OUTCHAR: need = 0;
            OP_DUP, OP_DROP, OP_NOT, OP_LSTART, OP_LEND, OP_OUTNUM: need = 1;
            default: need = 0;
        endcase
        if (stack_depth < need) begin
            issue(OP_PUSH, pick_word());
            return;
        end
        case (k)
            OP_PUSH, OP_INCHAR, OP_INNUM, OP_DUP: begin
                if (stack_depth >= StackDepthDef) issue(OP_DROP);
                else issue(k, pick_word(), {$urandom, $urandom});
            end
            OP_DIV, OP_MOD: begin
                // nonzero divisor pushed right before
                if (stack_depth >= StackDepthDef) issue(OP_DROP);
                b = ($urandom_range(0, 3) == 0) ? '1 : pick_word();
                if (b == 0) b = 64'd3;
                issue(OP_PUSH, b);
                issue(k);
            end
            OP_OUTCHAR: begin
                if (stack_depth >= StackDepthDef) issue(OP_DROP);
                issue(OP_PUSH, pick_code_point());
                issue(OP_OUTCHAR);
            end
            default: issue(k, {$urandom, $urandom}, {$urandom, $urandom});
        endcase
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every opcode, division by minus one, untaken jumps, unused codes
        issue(OP_PUSH, 64'h8000_0000_0000_0000);
        issue(OP_PUSH, '1);
        issue(OP_DIV);
        issue(OP_PUSH, '1);
        issue(OP_MOD);
        issue(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        issue(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        issue(OP_ADD);
        issue(OP_PUSH, -64'd7);
        issue(OP_PUSH, 64'd2);
        issue(OP_MOD);
        issue(OP_MUL);
        issue(OP_INNUM, '0, 64'h8000_0000_0000_0000);
        issue(OP_GT);
        issue(OP_LSTART, 64'hFFFF_FFFF_FFFF_1234);
        issue(OP_NOT);
        issue(OP_LEND, 64'hAAAA_5555_0000_FFFF);
        issue(OP_DUP);
        issue(OP_SWAP);
        issue(OP_SUB);
        issue(OP_OUTNUM);
        issue(OP_INCHAR, '1, 64'h10FFFF);
        issue(OP_OUTCHAR);
        issue(5'd31, '1, '1);
        issue(OP_DROP);
        drain();

        // fill the stack to the top, then swap, add and dup there
        while (stack_depth < StackDepthDef) issue(OP_PUSH, pick_word());
        issue(OP_SWAP);
        issue(OP_ADD);
        issue(OP_DUP);

        // random part with a long receiver hold-off and gap-free stretches
        sent = 0;
        while (sent < 1050) begin
            if (sent == 300) hold_request = 1;
            if (sent % 250 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (sent == 800) drain();
            random_instruction();
            sent++;
        end
        no_gaps = 0;
        drain();

        // one fault, then halted steps
        case ($urandom_range(0, 3))
            0: begin
                while (stack_depth > 0) issue(OP_DROP);
                issue(OP_DROP);
            end
            1: begin
                while (stack_depth < StackDepthDef) issue(OP_PUSH, pick_word());
                issue(OP_INNUM, '0, '1);
            end
            2: begin
                if (stack_depth >= StackDepthDef - 1) begin
                    issue(OP_DROP);
                    issue(OP_DROP);
                end
                issue(OP_PUSH, 64'd5);
                issue(OP_PUSH, '0);
                issue(OP_MOD);
            end
            default: begin
                if (stack_depth >= StackDepthDef) issue(OP_DROP);
                case ($urandom_range(0, 2))
                    0: issue(OP_PUSH, 64'hD800);
                    1: issue(OP_PUSH, 64'h110000);
                    default: issue(OP_PUSH, '1);
                endcase
                issue(OP_OUTCHAR);
            end
        endcase
        repeat (20) issue(5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom});

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("stack_machine_execute_unit_top: match");
        end else begin
            $display("stack_machine_execute_unit_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/smx_pkg.sv
rtl/smx_front.sv
rtl/smx_divider.sv
rtl/smx_back.sv
rtl/stack_machine_execute_unit_top.sv
tb/smx_checker.sv
tb/testbench.sv
